// File: src/pomb_pkg.sv
// Shared types and constants for the pixel object marker / bounding box unit.
package pomb_pkg;

   localparam int CH_W    = 8;
   localparam int FLAG_W  = 4;
   localparam int POS_W   = 12;
   localparam int CNT_W   = 24;
   localparam int WIDTH_W = 13;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [FLAG_W-1:0]  BG_FLAG   = 4'd4;
   localparam logic [FLAG_W-1:0]  MISSING_A = 4'd2;
   localparam logic [FLAG_W-1:0]  MISSING_B = 4'd3;
   localparam logic [POS_W-1:0]   POS_MAX   = '1;
   localparam logic [CNT_W-1:0]   COUNT_MAX = '1;

   localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = 13'd640;
   localparam logic [FLAG_W-1:0]  RST_OBJECT_FLAG = 4'd1;
   localparam logic [CH_W-1:0]    RST_THRESHOLD   = 8'd230;

   // register index = paddr[3:2]
   localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
   localparam logic [1:0] REG_OBJECT_FLAG = 2'd1;
   localparam logic [1:0] REG_THRESHOLD   = 2'd2;

   typedef struct packed {
      logic [WIDTH_W-1:0] image_width;
      logic [FLAG_W-1:0]  object_flag;
      logic [CH_W-1:0]    light_threshold;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic [FLAG_W-1:0] old_flag;
      logic              last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [FLAG_W-1:0] new_flag;
      logic              frame_done;
      logic              object_found;
      logic [CNT_W-1:0]  object_count;
      logic [POS_W-1:0]  box_left;
      logic [POS_W-1:0]  box_top;
      logic [POS_W-1:0]  box_right;
      logic [POS_W-1:0]  box_bottom;
   } result_type;

endpackage

// File: src/pomb_csr.sv
// Configuration registers behind the APB-style port.
module pomb_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pomb_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [pomb_pkg::DATA_W-1:0] csr_pwdata,
   output logic [pomb_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output pomb_pkg::cfg_type           cfg
);
   import pomb_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_IMAGE_WIDTH: cfg_in.image_width     = csr_pwdata[WIDTH_W-1:0];
            REG_OBJECT_FLAG: cfg_in.object_flag     = csr_pwdata[FLAG_W-1:0];
            REG_THRESHOLD:   cfg_in.light_threshold = csr_pwdata[CH_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH: csr_prdata = DATA_W'(cfg_ff.image_width);
         REG_OBJECT_FLAG: csr_prdata = DATA_W'(cfg_ff.object_flag);
         REG_THRESHOLD:   csr_prdata = DATA_W'(cfg_ff.light_threshold);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= RST_IMAGE_WIDTH;
         cfg_ff.object_flag     <= RST_OBJECT_FLAG;
         cfg_ff.light_threshold <= RST_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/pomb_frame_stats.sv
// Pixel classification and per-frame count / bounding box state.
module pomb_frame_stats (
   input  logic                 clock,
   input  logic                 reset,
   input  pomb_pkg::cfg_type    cfg,
   input  pomb_pkg::pixel_type  pix,
   input  logic                 fire,
   output pomb_pkg::result_type res
);
   import pomb_pkg::*;

   logic [POS_W-1:0]   col_ff, col_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   tally_ff, tally_in;
   logic               seen_ff, seen_in;
   logic [POS_W-1:0]   min_col_ff, min_col_in;
   logic [POS_W-1:0]   min_row_ff, min_row_in;
   logic [POS_W-1:0]   max_col_ff, max_col_in;
   logic [POS_W-1:0]   max_row_ff, max_row_in;

   logic               skip;
   logic               below;
   logic               obj;
   logic [WIDTH_W-1:0] col_next;
   logic               wrap;

   always_comb begin
      skip  = (pix.old_flag == MISSING_A) || (pix.old_flag == MISSING_B) ||
              (pix.red == '0 && pix.green == '0 && pix.blue == '0);
      below = (pix.red < cfg.light_threshold) || (pix.green < cfg.light_threshold) ||
              (pix.blue < cfg.light_threshold);
      obj   = !skip && below;

      // box and tally including this pixel
      tally_in   = (obj && tally_ff != COUNT_MAX) ? tally_ff + 1'b1 : tally_ff;
      seen_in    = seen_ff || obj;
      min_row_in = (obj && !seen_ff) ? row_ff : min_row_ff;
      max_row_in = obj ? row_ff : max_row_ff;
      max_col_in = (obj && col_ff > max_col_ff) ? col_ff : max_col_ff;
      min_col_in = (obj && col_ff < min_col_ff) ? col_ff : min_col_ff;

      res = '0;
      res.new_flag   = skip ? pix.old_flag : (obj ? cfg.object_flag : BG_FLAG);
      res.frame_done = pix.last_pixel;
      if (pix.last_pixel) begin
         res.object_found = seen_in;
         res.object_count = tally_in;
         if (seen_in) begin
            res.box_left   = min_col_in;
            res.box_top    = min_row_in;
            res.box_right  = max_col_in;
            res.box_bottom = max_row_in;
         end
      end

      // raster position; a row also ends at the largest column
      col_next = {1'b0, col_ff} + 1'b1;
      wrap     = (col_next >= cfg.image_width) || (col_ff == POS_MAX);
      col_in   = wrap ? '0 : col_next[POS_W-1:0];
      row_in   = (wrap && row_ff != POS_MAX) ? row_ff + 1'b1 : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && pix.last_pixel)) begin
         col_ff     <= '0;
         row_ff     <= '0;
         tally_ff   <= '0;
         seen_ff    <= 1'b0;
         min_col_ff <= POS_MAX;
         min_row_ff <= '0;
         max_col_ff <= '0;
         max_row_ff <= '0;
      end else if (fire) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         tally_ff   <= tally_in;
         seen_ff    <= seen_in;
         min_col_ff <= min_col_in;
         min_row_ff <= min_row_in;
         max_col_ff <= max_col_in;
         max_row_ff <= max_row_in;
      end
   end

endmodule

// File: src/pixel_object_marker_bbox_unit.sv
// Top level: input word register, classification stage, result register.
// An accepted req word passes through the input reg and then the result reg to its rsp word.
// Throughput: one pixel per clock; both stages advance together when the result
// register is empty or being drained.
// Reset (synchronous, active high) empties both stages, clears the frame count,
// box and raster position, and loads the register defaults 640 / 1 / 230.
module pixel_object_marker_bbox_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,  // red[7:0], green[15:8], blue[23:16]
   input  logic [3:0]                  req_tuser,  // old_flag[3:0]
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // object_found[0], object_count[24:1], box_left[36:25], box_top[48:37],
   // box_right[60:49], box_bottom[72:61], zero pad [79:73]
   output logic [79:0]                 rsp_tdata,
   output logic [3:0]                  rsp_tuser,  // new_flag[3:0]
   output logic                        rsp_tlast,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pomb_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [pomb_pkg::DATA_W-1:0] csr_pwdata,
   output logic [pomb_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);
   import pomb_pkg::*;

   cfg_type    cfg;
   pixel_type  pix_ff, pix_in;
   logic       pix_vld_ff;
   result_type res;
   result_type res_ff;
   logic       res_vld_ff;
   logic       res_open;
   logic       fire;
   logic       req_fire;

   pomb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pomb_frame_stats u_stats (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .pix   (pix_ff),
      .fire  (fire),
      .res   (res)
   );

   assign res_open   = !res_vld_ff || rsp_tready;
   assign fire       = pix_vld_ff && res_open;
   assign req_tready = !pix_vld_ff || res_open;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      pix_in.red        = req_tdata[7:0];
      pix_in.green      = req_tdata[15:8];
      pix_in.blue       = req_tdata[23:16];
      pix_in.old_flag   = req_tuser;
      pix_in.last_pixel = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_vld_ff <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            pix_vld_ff <= 1'b1;
         end else if (fire) begin
            pix_vld_ff <= 1'b0;
         end
         if (fire) begin
            res_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            res_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pix_ff <= pix_in;
      end
      if (fire) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = res_vld_ff;
   assign rsp_tuser  = res_ff.new_flag;
   assign rsp_tlast  = res_ff.frame_done;
   assign rsp_tdata  = {7'd0, res_ff.box_bottom, res_ff.box_right, res_ff.box_top,
                        res_ff.box_left, res_ff.object_count, res_ff.object_found};

endmodule
